FILE: rtl/gid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_pkg
// Shared types, codes and helpers of the graphic item deframer.
// ----------------------------------------------------------------------------
package gid_pkg;

  // Framing sizes
  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned FooterBytes = 5;
  localparam int unsigned SigDepth    = 10;
  localparam int unsigned SigIdxW     = $clog2(SigDepth + 1);

  // Result status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StBadVersion = 3'd1;
  localparam logic [2:0] StUnknownSig = 3'd2;
  localparam logic [2:0] StTruncHdr   = 3'd3;
  localparam logic [2:0] StTruncPay   = 3'd4;

  // Format codes
  localparam logic [2:0] FmtNone = 3'd0;
  localparam logic [2:0] FmtPng  = 3'd1;
  localparam logic [2:0] FmtEps  = 3'd2;
  localparam logic [2:0] FmtJpg  = 3'd3;
  localparam logic [2:0] FmtGif  = 3'd4;
  localparam logic [2:0] FmtPdf  = 3'd5;
  localparam logic [2:0] FmtTif  = 3'd6;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_block;
    logic       first_of_file;
  } gid_in_t;

  // Result transfer payload
  typedef struct packed {
    logic [15:0] graphic_index;
    logic [2:0]  status;
    logic [2:0]  format;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } gid_out_t;

  // Leading payload bytes, entry 0 is the first payload byte
  typedef logic [SigDepth-1:0][7:0] gid_sig_t;

  // Merge one byte into a 32-bit field in the selected byte order
  function automatic logic [31:0] put_byte(logic [31:0] acc, logic [1:0] pos,
                                           logic [7:0] b, logic be);
    logic [31:0] res;
    if (be) begin
      res = {acc[23:0], b};
    end else begin
      res = acc | ({24'd0, b} << {pos, 3'b000});
    end
    return res;
  endfunction

endpackage

FILE: rtl/gid_sniff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_sniff
// Format detection from the leading payload bytes, gated by payload length.
// ----------------------------------------------------------------------------
module gid_sniff (
  input  gid_pkg::gid_sig_t sig_i,
  input  logic [31:0]       len_i,
  output logic [2:0]        fmt_o
);
  import gid_pkg::*;

  logic is_png, is_eps_bin, is_jpg, is_gif, is_pdf, is_tif, is_eps_txt;

  // Individual signature matches
  always_comb begin
    is_png = (len_i >= 32'd8) && sig_i[0] == 8'h89 && sig_i[1] == 8'h50 &&
             sig_i[2] == 8'h4e && sig_i[3] == 8'h47;
    is_eps_bin = (len_i >= 32'd4) && sig_i[0] == 8'hc5 && sig_i[1] == 8'hd0 &&
                 sig_i[2] == 8'hd3 && sig_i[3] == 8'hc6;
    is_jpg = (len_i >= 32'd3) && sig_i[0] == 8'hff && sig_i[1] == 8'hd8 &&
             sig_i[2] == 8'hff;
    is_gif = (len_i >= 32'd6) && sig_i[0] == 8'h47 && sig_i[1] == 8'h49 &&
             sig_i[2] == 8'h46 && sig_i[3] == 8'h38 &&
             (sig_i[4] == 8'h37 || sig_i[4] == 8'h39) && sig_i[5] == 8'h61;
    is_pdf = (len_i >= 32'd5) && sig_i[0] == 8'h25 && sig_i[1] == 8'h50 &&
             sig_i[2] == 8'h44 && sig_i[3] == 8'h46 && sig_i[4] == 8'h2d;
    is_tif = (len_i >= 32'd4) &&
             ((sig_i[0] == 8'h49 && sig_i[1] == 8'h49 && sig_i[2] == 8'h2a &&
               sig_i[3] == 8'h00) ||
              (sig_i[0] == 8'h4d && sig_i[1] == 8'h4d && sig_i[2] == 8'h00 &&
               sig_i[3] == 8'h2a));
    // ten-byte text EPS header
    is_eps_txt = (len_i >= 32'd10) && sig_i[0] == 8'h25 && sig_i[1] == 8'h21 &&
                 sig_i[2] == 8'h50 && sig_i[3] == 8'h53 && sig_i[4] == 8'h2d &&
                 sig_i[5] == 8'h41 && sig_i[6] == 8'h64 && sig_i[7] == 8'h6f &&
                 sig_i[8] == 8'h62 && sig_i[9] == 8'h65;
  end

  // Priority order of the tests
  always_comb begin
    if (is_png) begin
      fmt_o = FmtPng;
    end else if (is_eps_bin) begin
      fmt_o = FmtEps;
    end else if (is_jpg) begin
      fmt_o = FmtJpg;
    end else if (is_gif) begin
      fmt_o = FmtGif;
    end else if (is_pdf) begin
      fmt_o = FmtPdf;
    end else if (is_tif) begin
      fmt_o = FmtTif;
    end else if (is_eps_txt) begin
      fmt_o = FmtEps;
    end else begin
      fmt_o = FmtNone;
    end
  end

endmodule

FILE: rtl/graphic_item_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graphic_item_deframer_core
// Splits a byte stream of graphics blocks into items and reports each one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one block byte per transfer (in_valid_i / in_stall_o), with
//   last_of_block on the final byte of a block and first_of_file restarting
//   item numbering. Output channel: one result per completed item, or per
//   block that ends inside an item (out_valid_o / out_stall_i).
//   cfg_we_i / cfg_wdata_i set the byte order of length and version fields;
//   write it only while no byte is in flight.
//   Throughput: one byte per cycle while the receiver does not stall, set by the
//   combinational update of the framing state between the input and result registers.
//   The byte that causes a result is held in the input register; the framing
//   update then writes that result into the result register.
//   Reset: framing restarts at a header, block offset 0, item number 1,
//   little-endian order; no result is pending.
//   Receiver stall: the result register holds its content; at most one more byte
//   is taken into the input register, then in_stall_o stays high until the
//   waiting result is transferred.
// ----------------------------------------------------------------------------
module graphic_item_deframer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gid_pkg::gid_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gid_pkg::gid_out_t out_data_o
);
  import gid_pkg::*;

  // Framing phase codes
  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhFooter  = 2'd2;

  logic               big_endian_q;
  logic               in_valid_q;
  gid_in_t            in_q;
  logic               out_valid_q;
  gid_out_t           out_q;

  logic [1:0]         phase_q, phase_d;
  logic [2:0]         fpos_q, fpos_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        ver_q, ver_d;
  logic [31:0]        start_q, start_d;
  logic [31:0]        boff_q, boff_d;
  logic [15:0]        cnt_q, cnt_d;
  logic [SigIdxW-1:0] sig_idx_q, sig_idx_d;
  gid_sig_t           sig_q;
  logic               sig_we;

  logic               advance;
  logic               emit;
  gid_out_t           res;
  logic [2:0]         sniff_fmt;
  logic [15:0]        cnt_eff;
  logic [31:0]        hdr_len;
  logic [31:0]        ver_base;
  logic [31:0]        rem_dec;

  // Handshake: process the held byte when the result register can take it
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Format detection on the stored leading bytes
  gid_sniff u_sniff (
    .sig_i (sig_q),
    .len_i (len_q),
    .fmt_o (sniff_fmt)
  );

  // Per-byte framing update
  always_comb begin
    phase_d   = phase_q;
    fpos_d    = fpos_q;
    len_d     = len_q;
    rem_d     = rem_q;
    ver_d     = ver_q;
    start_d   = start_q;
    sig_idx_d = sig_idx_q;
    sig_we    = 1'b0;
    emit      = 1'b0;

    cnt_eff  = in_q.first_of_file ? 16'd1 : cnt_q;
    cnt_d    = cnt_eff;
    hdr_len  = (fpos_q == 3'd0) ? 32'd0 : len_q;
    ver_base = (fpos_q == 3'd0) ? 32'd0 : ver_q;
    rem_dec  = rem_q - 32'd1;

    res.graphic_index  = cnt_eff;
    res.status         = StTruncPay;
    res.format         = FmtNone;
    res.payload_offset = start_q;
    res.payload_length = len_q;

    unique case (phase_q)
      PhPayload: begin
        sig_we = (sig_idx_q < SigIdxW'(SigDepth));
        if (sig_we) begin
          sig_idx_d = sig_idx_q + SigIdxW'(1);
        end
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PhFooter;
          fpos_d  = 3'd0;
        end
        emit = in_q.last_of_block;
      end
      PhFooter: begin
        if (fpos_q < 3'(FooterBytes - 1)) begin
          ver_d  = put_byte(ver_base, fpos_q[1:0], in_q.data_byte, big_endian_q);
          fpos_d = fpos_q + 3'd1;
          emit   = in_q.last_of_block;
        end else begin
          // item complete
          emit = 1'b1;
          if (ver_q != 32'd1) begin
            res.status = StBadVersion;
          end else begin
            res.format = sniff_fmt;
            res.status = (sniff_fmt != FmtNone) ? StOk : StUnknownSig;
          end
          if (cnt_eff != 16'hffff) begin
            cnt_d = cnt_eff + 16'd1;
          end
          phase_d = PhHeader;
          fpos_d  = 3'd0;
        end
      end
      default: begin
        // header bytes 2..5 carry the payload length
        if (fpos_q >= 3'd2) begin
          hdr_len = put_byte(hdr_len, fpos_q[1:0] - 2'd2, in_q.data_byte,
                             big_endian_q);
        end
        len_d = hdr_len;
        if (fpos_q >= 3'(HeaderBytes - 1)) begin
          fpos_d    = 3'd0;
          start_d   = boff_q + 32'd1;
          sig_idx_d = '0;
          rem_d     = hdr_len;
          phase_d   = (hdr_len == 32'd0) ? PhFooter : PhPayload;
          res.payload_offset = boff_q + 32'd1;
          res.payload_length = hdr_len;
        end else begin
          fpos_d             = fpos_q + 3'd1;
          res.status         = StTruncHdr;
          res.payload_offset = 32'd0;
          res.payload_length = 32'd0;
        end
        emit = in_q.last_of_block;
      end
    endcase

    // end of block restarts framing
    if (in_q.last_of_block) begin
      phase_d = PhHeader;
      fpos_d  = 3'd0;
      boff_d  = 32'd0;
    end else begin
      boff_d  = boff_q + 32'd1;
    end
  end

  // Framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      fpos_q    <= 3'd0;
      len_q     <= 32'd0;
      rem_q     <= 32'd0;
      ver_q     <= 32'd0;
      start_q   <= 32'd0;
      boff_q    <= 32'd0;
      cnt_q     <= 16'd1;
      sig_idx_q <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      fpos_q    <= fpos_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      ver_q     <= ver_d;
      start_q   <= start_d;
      boff_q    <= boff_d;
      cnt_q     <= cnt_d;
      sig_idx_q <= sig_idx_d;
    end
  end

  // Leading payload bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= '0;
    end else begin
      for (int i = 0; i < SigDepth; i++) begin
        if (advance && sig_we && sig_idx_q == SigIdxW'(i)) begin
          sig_q[i] <= in_q.data_byte;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

endmodule

FILE: rtl/gid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gid_checker
// Port-level checks of the graphic item deframer results.
// ----------------------------------------------------------------------------
module gid_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gid_pkg::gid_out_t out_data_o
);
  import gid_pkg::*;

  // A held result stays put until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An ok result, and only an ok result, carries a format
  a_fmt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == StOk) == (out_data_o.format != FmtNone)))
    else $error("format and status disagree");

  // Truncated header reports no payload
  a_trunc_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StTruncHdr |->
      out_data_o.payload_offset == 32'd0 && out_data_o.payload_length == 32'd0)
    else $error("truncated header with payload fields");

  // Item numbering starts at one and never wraps to zero
  a_index_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.graphic_index != 16'd0)
    else $error("zero item number");

endmodule

bind graphic_item_deframer_core gid_checker u_gid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: bench/tb_graphic_item_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graphic_item_deframer_core
// Self-checking bench for the graphic item deframer. Byte streams built from
// well-formed items (every signature, length gates, bad versions, truncated
// blocks, byte order changes) are pushed through the input channel with
// random gaps. A local model of the framing predicts every result, and the
// results are compared field by field in arrival order. A long receiver
// stall and item number restarts are covered as well.
// ----------------------------------------------------------------------------
module tb_graphic_item_deframer_core;
  import gid_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxPrinted = 100;
  localparam int unsigned ByteGoal   = 1800;

  // Framing phase of the local model
  typedef enum logic [1:0] {PhHeader, PhPayload, PhFooter} frame_phase_e;

  // Leading payload bytes that the stimulus can place in an item
  typedef enum int {
    LeadNoise, LeadPng, LeadEpsBin, LeadJpg, LeadGif87, LeadGif89,
    LeadPdf, LeadTifLe, LeadTifBe, LeadEpsText
  } lead_kind_e;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     in_valid_i;
  logic     in_stall_o;
  gid_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  gid_out_t out_data_o;

  graphic_item_deframer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Model state
  bit           m_be;
  frame_phase_e m_phase;
  logic [2:0]   m_pos;
  logic [31:0]  m_len;
  logic [31:0]  m_left;
  logic [7:0]   m_sig [SigDepth];
  logic [31:0]  m_ver;
  logic [15:0]  m_item;
  logic [31:0]  m_boff;

  // Bench bookkeeping
  gid_out_t    expected_q [$];
  gid_in_t     pending_q [$];
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int          src_gap_max;
  int          sink_gap_max;
  int          sink_hold;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_graphic_item_deframer_core: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the framing
  // ---------------------------------------------------------------------------
  function automatic void reset_model();
    m_be    = 1'b0;
    m_phase = PhHeader;
    m_pos   = '0;
    m_len   = '0;
    m_left  = '0;
    m_ver   = '0;
    m_item  = 16'd1;
    m_boff  = '0;
    foreach (m_sig[i]) m_sig[i] = '0;
  endfunction

  // Merge one byte into a length or version word in the current byte order
  function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [1:0] pos,
                                             input logic [7:0] b);
    if (m_be) return {acc[23:0], b};
    return acc | (32'(b) << (8 * pos));
  endfunction

  // Sniff the format from the stored leading bytes; each test needs enough length
  function automatic logic [2:0] detect_format(input logic [31:0] len);
    logic [2:0] fm;
    fm = FmtNone;
    if (len >= 8 && {m_sig[0], m_sig[1], m_sig[2], m_sig[3]} == 32'h8950_4e47)
      fm = FmtPng;
    else if (len >= 4 && {m_sig[0], m_sig[1], m_sig[2], m_sig[3]} == 32'hc5d0_d3c6)
      fm = FmtEps;
    else if (len >= 3 && {m_sig[0], m_sig[1], m_sig[2]} == 24'hffd8ff)
      fm = FmtJpg;
    else if (len >= 6 && {m_sig[0], m_sig[1], m_sig[2], m_sig[3]} == 32'h4749_4638 &&
             (m_sig[4] == 8'h37 || m_sig[4] == 8'h39) && m_sig[5] == 8'h61)
      fm = FmtGif;
    else if (len >= 5 &&
             {m_sig[0], m_sig[1], m_sig[2], m_sig[3], m_sig[4]} == 40'h25_5044_462d)
      fm = FmtPdf;
    else if (len >= 4 && ({m_sig[0], m_sig[1], m_sig[2], m_sig[3]} == 32'h4949_2a00 ||
                          {m_sig[0], m_sig[1], m_sig[2], m_sig[3]} == 32'h4d4d_002a))
      fm = FmtTif;
    else if (len >= 10 &&
             {m_sig[0], m_sig[1], m_sig[2], m_sig[3], m_sig[4], m_sig[5], m_sig[6],
              m_sig[7], m_sig[8], m_sig[9]} == 80'h2521_5053_2d41_646f_6265)
      fm = FmtEps;
    return fm;
  endfunction

  function automatic gid_out_t make_result(input logic [2:0] st, input logic [2:0] fm,
                                           input logic [31:0] off, input logic [31:0] len);
    gid_out_t r;
    r.graphic_index  = m_item;
    r.status         = st;
    r.format         = fm;
    r.payload_offset = off;
    r.payload_length = len;
    return r;
  endfunction

  // Advance the model by one byte; hit tells whether a result follows
  function automatic void predict_byte(input gid_in_t d, output bit hit, output gid_out_t r);
    logic [31:0] off;
    logic [31:0] k;
    logic [2:0]  sel;
    logic [2:0]  st;
    logic [2:0]  fm;
    bit          done;
    off  = m_boff;
    hit  = 1'b0;
    r    = '0;
    done = 1'b0;
    if (d.first_of_file) m_item = 16'd1;
    case (m_phase)
      PhPayload: begin
        k = m_len - m_left;
        if (k < SigDepth) m_sig[k] = d.data_byte;
        m_left = m_left - 32'd1;
        if (m_left == 0) begin
          m_phase = PhFooter;
          m_pos   = '0;
        end
        if (d.last_of_block) begin
          hit = 1'b1;
          r   = make_result(StTruncPay, FmtNone, off - k, m_len);
        end
      end
      PhFooter: begin
        if (m_pos == 0) m_ver = '0;
        if (m_pos < 4) begin
          m_ver = merge_byte(m_ver, m_pos[1:0], d.data_byte);
          m_pos = m_pos + 3'd1;
          if (d.last_of_block) begin
            hit = 1'b1;
            r   = make_result(StTruncPay, FmtNone, off - m_len - 32'(m_pos) + 32'd1, m_len);
          end
        end else begin
          // closing footer byte: the item is complete
          fm = FmtNone;
          if (m_ver != 32'd1) begin
            st = StBadVersion;
          end else begin
            fm = detect_format(m_len);
            st = (fm != FmtNone) ? StOk : StUnknownSig;
          end
          hit = 1'b1;
          r   = make_result(st, fm, off - m_len - 32'd4, m_len);
          if (m_item != 16'hffff) m_item = m_item + 16'd1;
          m_phase = PhHeader;
          m_pos   = '0;
        end
      end
      default: begin
        if (m_pos == 0) m_len = '0;
        if (m_pos >= 2) begin
          sel   = m_pos - 3'd2;
          m_len = merge_byte(m_len, sel[1:0], d.data_byte);
        end
        if (m_pos >= HeaderBytes - 1) begin
          done  = 1'b1;
          m_pos = '0;
          if (m_len == 0) begin
            m_phase = PhFooter;
          end else begin
            m_phase = PhPayload;
            m_left  = m_len;
          end
        end else begin
          m_pos = m_pos + 3'd1;
        end
        if (d.last_of_block) begin
          hit = 1'b1;
          if (done) r = make_result(StTruncPay, FmtNone, off + 32'd1, m_len);
          else      r = make_result(StTruncHdr, FmtNone, 32'd0, 32'd0);
        end
      end
    endcase
    // a block end always restarts framing at offset 0
    if (d.last_of_block) begin
      m_phase = PhHeader;
      m_pos   = '0;
      m_boff  = '0;
    end else begin
      m_boff = off + 32'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(input gid_out_t got);
    gid_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing pending", got.graphic_index, 32'd0);
      return;
    end
    want = expected_q.pop_front();
    if (got.graphic_index !== want.graphic_index)
      report_mismatch("graphic_index", got.graphic_index, want.graphic_index);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.format !== want.format)
      report_mismatch("format", got.format, want.format);
    if (got.payload_offset !== want.payload_offset)
      report_mismatch("payload_offset", got.payload_offset, want.payload_offset);
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", got.payload_length, want.payload_length);
  endtask

  // Result side: per-transfer random stall, plus a long hold on request
  initial begin : result_sink
    bit took;
    int sink_wait;
    sink_wait = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      took = (out_valid_o === 1'b1) && !out_stall_i;
      if (took) check_result(out_data_o);
      if (sink_hold > 0) begin
        sink_hold--;
        sink_wait = 0;
        out_stall_i <= 1'b1;
      end else begin
        if (took) sink_wait = $urandom_range(sink_gap_max, 0);
        else if (sink_wait > 0) sink_wait--;
        out_stall_i <= (sink_wait != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_byte(input gid_in_t item);
    int       gap;
    bit       hit;
    gid_out_t want;
    gap = $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    predict_byte(item, hit, want);
    if (hit) expected_q.insert(expected_q.size(), want);
  endtask

  task automatic flush_stream();
    while (pending_q.size() != 0) send_byte(pending_q.pop_front());
  endtask

  // Mark the final queued byte as the block end, then send everything
  task automatic send_block();
    gid_in_t tail;
    tail = pending_q.pop_back();
    tail.last_of_block = 1'b1;
    pending_q.insert(pending_q.size(), tail);
    flush_stream();
  endtask

  // Stop offering and let every pending result come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(input bit be);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= be;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    m_be = be;
  endtask

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    gid_in_t e;
    e = '0;
    e.data_byte = b;
    pending_q.insert(pending_q.size(), e);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(m_be ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
  endfunction

  function automatic void add_header(input logic [31:0] len);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    put_word(len);
  endfunction

  function automatic void trim_tail(input int k);
    repeat (k) pending_q.delete(pending_q.size() - 1);
  endfunction

  function automatic void mark_file_start(input int idx);
    gid_in_t head;
    head = pending_q[idx];
    head.first_of_file = 1'b1;
    pending_q[idx] = head;
  endfunction

  // Signature bytes of a format; the count is also the least length it needs
  function automatic int lead_bytes(input lead_kind_e kind, output logic [7:0] lb [SigDepth]);
    lb = '{default: 8'h00};
    case (kind)
      LeadPng: begin
        lb = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a, 8'h00, 8'h00};
        return 8;
      end
      LeadEpsBin: begin
        lb = '{8'hc5, 8'hd0, 8'hd3, 8'hc6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        return 4;
      end
      LeadJpg: begin
        lb = '{8'hff, 8'hd8, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        return 3;
      end
      LeadGif87: begin
        lb = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00};
        return 6;
      end
      LeadGif89: begin
        lb = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00};
        return 6;
      end
      LeadPdf: begin
        lb = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        return 5;
      end
      LeadTifLe: begin
        lb = '{8'h49, 8'h49, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        return 4;
      end
      LeadTifBe: begin
        lb = '{8'h4d, 8'h4d, 8'h00, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        return 4;
      end
      LeadEpsText: begin
        // text EPS header
        lb = '{8'h25, 8'h21, 8'h50, 8'h53, 8'h2d, 8'h41, 8'h64, 8'h6f, 8'h62, 8'h65};
        return 10;
      end
      default: return 0;
    endcase
  endfunction

  // One whole item; flip >= 0 replaces that signature byte with a random one
  function automatic void add_item(input logic [31:0] len, input lead_kind_e kind,
                                   input logic [31:0] ver, input int flip);
    logic [7:0] lb [SigDepth];
    int         n;
    n = lead_bytes(kind, lb);
    add_header(len);
    for (int unsigned i = 0; i < len; i++)
      add_byte((i < n && i != flip) ? lb[i] : 8'($urandom));
    put_word(ver);
    add_byte(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every format, the length gates, bad version and zero length, little endian
  task automatic test_formats_le();
    int first;
    write_order(1'b0);
    add_item(8, LeadPng, 32'd1, -1);
    add_item(4, LeadEpsBin, 32'd1, -1);
    add_item(3, LeadJpg, 32'd1, -1);
    add_item(6, LeadGif87, 32'd1, -1);
    add_item(6, LeadGif89, 32'd1, -1);
    add_item(5, LeadPdf, 32'd1, -1);
    add_item(4, LeadTifLe, 32'd1, -1);
    add_item(4, LeadTifBe, 32'd1, -1);
    add_item(10, LeadEpsText, 32'd1, -1);
    send_block();
    // one byte short of what the PNG, JPG, GIF and text EPS signatures need
    add_item(7, LeadPng, 32'd1, -1);
    add_item(2, LeadJpg, 32'd1, -1);
    add_item(5, LeadGif89, 32'd1, -1);
    add_item(9, LeadEpsText, 32'd1, -1);
    add_item(0, LeadNoise, 32'd1, -1);
    add_item(12, LeadNoise, 32'd1, -1);
    add_item(8, LeadPng, 32'd0, -1);
    add_item(5, LeadPdf, 32'hffff_ffff, -1);
    first = pending_q.size();
    add_item(6, LeadGif87, 32'd1, -1);
    mark_file_start(first);
    send_block();
    wait_idle();
  endtask

  task automatic test_formats_be();
    write_order(1'b1);
    add_item(8, LeadPng, 32'd1, -1);
    add_item(260, LeadPdf, 32'd1, -1);
    add_item(0, LeadNoise, 32'h0100_0000, -1);
    add_item(4, LeadTifBe, 32'd1, -1);
    send_block();
    wait_idle();
  endtask

  // Blocks that end inside an item, then a clean one
  task automatic test_truncation();
    write_order(1'b0);
    add_byte(8'($urandom));
    send_block();
    repeat (4) add_byte(8'($urandom));
    send_block();
    // header completes on the block's last byte
    add_header(32'd5);
    send_block();
    add_header(32'hffff_ffff);
    repeat (7) add_byte(8'($urandom));
    send_block();
    // footer cut after two version bytes
    add_item(3, LeadJpg, 32'd1, -1);
    trim_tail(3);
    send_block();
    // cut on the last version byte
    add_item(0, LeadNoise, 32'd1, -1);
    trim_tail(1);
    send_block();
    add_item(2, LeadNoise, 32'd1, -1);
    add_item(3, LeadJpg, 32'd1, -1);
    send_block();
    wait_idle();
  endtask

  // Byte order switched while the block sits in the middle of a field
  task automatic test_order_switch();
    write_order(1'b0);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(8'h12);
    add_byte(8'h34);
    flush_stream();
    wait_idle();
    write_order(1'b1);
    add_byte(8'h56);
    add_byte(8'h78);
    repeat (3) add_byte(8'($urandom));
    send_block();
    wait_idle();
    // version: three bytes little endian, the fourth big endian gives one
    write_order(1'b0);
    add_header(32'd3);
    add_byte(8'hff);
    add_byte(8'hd8);
    add_byte(8'hff);
    repeat (3) add_byte(8'h00);
    flush_stream();
    wait_idle();
    write_order(1'b1);
    add_byte(8'h01);
    add_byte(8'($urandom));
    send_block();
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps pushing
  task automatic test_back_pressure();
    src_gap_max = 0;
    sink_hold   = 300;
    for (int i = 0; i < 40; i++) begin
      if (i[0]) add_item(3, LeadJpg, 32'd1, -1);
      else      add_item(0, LeadNoise, 32'd1, -1);
    end
    send_block();
    wait_idle();
  endtask

  // Mostly well-formed items with random content, some noise and cut blocks
  task automatic random_block();
    int          n_items;
    int          first;
    int          flip;
    int          cut;
    logic [31:0] len;
    logic [31:0] ver;
    lead_kind_e  kind;
    n_items = $urandom_range(4, 1);
    for (int j = 0; j < n_items; j++) begin
      first = pending_q.size();
      kind  = lead_kind_e'($urandom_range(9, 0));
      case ($urandom_range(9, 0))
        0, 1:    len = $urandom_range(40, 17);
        2:       len = $urandom_range(3, 0);
        default: len = $urandom_range(12, 0);
      endcase
      if (kind != LeadNoise && $urandom_range(1, 0) == 1) len = len + 32'd10;
      case ($urandom_range(11, 0))
        0:       ver = 32'd0;
        1:       ver = 32'h0000_0100;
        2:       ver = 32'h0100_0000;
        3:       ver = $urandom;
        default: ver = 32'd1;
      endcase
      flip = ($urandom_range(5, 0) == 0) ? $urandom_range(SigDepth - 1, 0) : -1;
      if ($urandom_range(15, 0) == 0) begin
        repeat ($urandom_range(8, 1)) add_byte(8'($urandom));
      end else begin
        add_item(len, kind, ver, flip);
      end
      if ($urandom_range(19, 0) == 0) mark_file_start(first);
    end
    if ($urandom_range(3, 0) == 0) begin
      cut = $urandom_range(14, 1);
      if (cut < pending_q.size()) trim_tail(cut);
    end
    send_block();
  endtask

  // Random blocks until the whole run has sent its share of bytes
  task automatic test_random_stream();
    while (bytes_sent < ByteGoal) begin
      wait_idle();
      if ($urandom_range(2, 0) == 0) write_order($urandom_range(1, 0));
      src_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 9;
      sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
      repeat ($urandom_range(5, 1)) random_block();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    error_count  = 0;
    bytes_sent   = 0;
    src_gap_max  = 9;
    sink_gap_max = 9;
    sink_hold    = 0;
    reset_model();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_formats_le();
    test_formats_be();
    test_truncation();
    test_order_switch();
    test_back_pressure();
    test_random_stream();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_graphic_item_deframer_core: done, clean");
    end else begin
      $display("tb_graphic_item_deframer_core: done, errors");
    end
    $finish;
  end

endmodule
